/* rtl/lcmp_pkg.sv */
// Shared constants, types and the hash function of the LZW byte compressor.
// No dependencies; every other file refers to it by scoped names.
package lcmp_pkg;

   localparam int CODE_BITS  = 12;
   localparam int DATA_BITS  = 8;
   localparam int OUT_CODE_W = 12;
   localparam int DICT_SIZE  = 1 << CODE_BITS;

   typedef logic [CODE_BITS-1:0]  code_type;
   typedef logic [CODE_BITS:0]    free_type;
   typedef logic [DATA_BITS-1:0]  data_type;
   typedef logic [OUT_CODE_W-1:0] out_code_type;

   localparam free_type FIRST_FREE = free_type'(256);
   localparam free_type FREE_LIMIT = free_type'(DICT_SIZE);

   // one slot of the open-addressed hash table
   typedef struct packed {
      code_type code;
      code_type prefix;
      data_type data;
   } hash_entry_type;

   typedef struct packed {
      logic accept;
      logic take_first;
      logic next_slot;
      logic hit;
      logic miss;
      logic pop;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic prefix_valid;
      logic in_final;
      logic fin;
      logic occupied;
      logic match;
   } status_type;

   function automatic code_type hash_slot(code_type prefix, data_type data);
      return prefix ^ (code_type'(data) << (CODE_BITS - DATA_BITS));
   endfunction

endpackage

/* rtl/lcmp_req_if.sv */
// Request channel: one input byte and its end-of-stream flag.
// Uses lcmp_pkg for the byte type.
interface lcmp_req_if;
   logic                valid;
   logic                ready;
   lcmp_pkg::data_type  in_byte;
   logic                in_final;

   modport source (output valid, output in_byte, output in_final, input ready);
   modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

/* rtl/lcmp_rsp_if.sv */
// Response channel: one emitted code and its last flag.
// Uses lcmp_pkg for the code type.
interface lcmp_rsp_if;
   logic                    valid;
   logic                    ready;
   lcmp_pkg::out_code_type  out_code;
   logic                    out_last;

   modport source (output valid, output out_code, output out_last, input ready);
   modport sink   (input valid, input out_code, input out_last, output ready);
endinterface

/* rtl/lzw_byte_compressor.sv */
// LZW compressor with fixed-width codes: one byte per request, up to two codes
// per byte on the response side, dictionary frozen once all codes are used and
// reset after each final byte. Dictionary lookups go through an open-addressed
// hash table in block memory with linear probing: a byte reads the hash memory,
// then the link memory, then checks the slot, and repeats those steps for each
// collided slot; each emitted code is held until it is taken, and a final byte
// also emits the last code of its stream. The first byte of a stream needs no
// probe. The hash memory read followed by the dependent link memory read sets the
// per-probe cost. No clearing pass is run after reset or between streams.
// Depends on lcmp_pkg, lcmp_req_if, lcmp_rsp_if, lcmp_ctrl and lcmp_dpath.
module lzw_byte_compressor (
   input  logic        clock,
   input  logic        reset,
   lcmp_req_if.sink    req,
   lcmp_rsp_if.source  rsp
);

   lcmp_pkg::cmd_type    cmd;
   lcmp_pkg::status_type st;

   lcmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .st        (st),
      .cmd       (cmd)
   );

   lcmp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .in_byte   (req.in_byte),
      .in_final  (req.in_final),
      .out_valid (rsp.valid),
      .out_code  (rsp.out_code),
      .out_last  (rsp.out_last)
   );

endmodule

/* rtl/lcmp_ctrl.sv */
// Controller of the LZW compressor: sequences accept, hash probe, emit.
// Depends on lcmp_pkg for the command and status structs.
module lcmp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  lcmp_pkg::status_type st,
   output lcmp_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_RD_HASH, S_RD_LINK, S_CHECK, S_SEND, S_FINISH, S_SEND_LAST
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!st.prefix_valid) begin
                  cmd.take_first = 1'b1;
                  state_in = st.in_final ? S_FINISH : S_IDLE;
               end else begin
                  state_in = S_RD_HASH;
               end
            end
         end
         S_RD_HASH: state_in = S_RD_LINK;
         S_RD_LINK: state_in = S_CHECK;
         S_CHECK: begin
            if (st.occupied && st.match) begin
               cmd.hit  = 1'b1;
               state_in = st.fin ? S_FINISH : S_IDLE;
            end else if (st.occupied) begin
               // collision: linear probe to the next slot
               cmd.next_slot = 1'b1;
               state_in      = S_RD_HASH;
            end else begin
               cmd.miss = 1'b1;
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ready) begin
               cmd.pop  = 1'b1;
               state_in = st.fin ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            cmd.emit_last = 1'b1;
            state_in      = S_SEND_LAST;
         end
         S_SEND_LAST: begin
            if (rsp_ready) begin
               cmd.pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/lcmp_dpath.sv */
// Datapath of the LZW compressor: prefix and free-code registers, the hash
// table and code-to-slot link memories, and the output register. Uses lcmp_pkg.
module lcmp_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  lcmp_pkg::cmd_type      cmd,
   output lcmp_pkg::status_type   st,
   input  lcmp_pkg::data_type     in_byte,
   input  logic                   in_final,
   output logic                   out_valid,
   output lcmp_pkg::out_code_type out_code,
   output logic                   out_last
);

   // Hash slot is live only if its code was issued in this stream and the
   // link memory points back at the slot, so no clearing pass is needed.
   lcmp_pkg::hash_entry_type hash_mem [lcmp_pkg::DICT_SIZE];
   lcmp_pkg::code_type       link_mem [lcmp_pkg::DICT_SIZE];

   lcmp_pkg::hash_entry_type hq_ff;
   lcmp_pkg::code_type       lq_ff;

   lcmp_pkg::data_type     data_ff, data_in;
   logic                   fin_ff, fin_in;
   lcmp_pkg::code_type     prefix_ff, prefix_in;
   logic                   pvalid_ff, pvalid_in;
   lcmp_pkg::free_type     free_ff, free_in;
   lcmp_pkg::code_type     slot_ff, slot_in;
   lcmp_pkg::out_code_type ocode_ff, ocode_in;
   logic                   olast_ff, olast_in;
   logic                   ovalid_ff, ovalid_in;

   logic full;
   logic do_write;

   assign full     = (free_ff == lcmp_pkg::FREE_LIMIT);
   assign do_write = cmd.miss && !full;

   always_comb begin
      st.prefix_valid = pvalid_ff;
      st.in_final     = in_final;
      st.fin          = fin_ff;
      st.occupied     = ({1'b0, hq_ff.code} >= lcmp_pkg::FIRST_FREE)
                        && ({1'b0, hq_ff.code} < free_ff)
                        && (lq_ff == slot_ff);
      st.match        = (hq_ff.prefix == prefix_ff) && (hq_ff.data == data_ff);
   end

   always_comb begin
      data_in   = data_ff;
      fin_in    = fin_ff;
      prefix_in = prefix_ff;
      pvalid_in = pvalid_ff;
      free_in   = free_ff;
      slot_in   = slot_ff;
      ocode_in  = ocode_ff;
      olast_in  = olast_ff;
      ovalid_in = ovalid_ff;

      if (cmd.accept) begin
         data_in = in_byte;
         fin_in  = in_final;
         slot_in = lcmp_pkg::hash_slot(prefix_ff, in_byte);
      end
      if (cmd.take_first) begin
         prefix_in = lcmp_pkg::code_type'(in_byte);
         pvalid_in = 1'b1;
      end
      if (cmd.next_slot) begin
         slot_in = slot_ff + 1'b1;
      end
      if (cmd.hit) begin
         prefix_in = hq_ff.code;
      end
      if (cmd.miss) begin
         ocode_in  = lcmp_pkg::out_code_type'(prefix_ff);
         olast_in  = 1'b0;
         ovalid_in = 1'b1;
         prefix_in = lcmp_pkg::code_type'(data_ff);
         if (!full) begin
            free_in = free_ff + 1'b1;
         end
      end
      if (cmd.pop) begin
         ovalid_in = 1'b0;
      end
      if (cmd.emit_last) begin
         ocode_in  = lcmp_pkg::out_code_type'(prefix_ff);
         olast_in  = 1'b1;
         ovalid_in = 1'b1;
         // stream ends: dictionary and prefix start over
         free_in   = lcmp_pkg::FIRST_FREE;
         prefix_in = '0;
         pvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         free_ff   <= lcmp_pkg::FIRST_FREE;
         prefix_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
         free_ff   <= free_in;
         prefix_ff <= prefix_in;
         ovalid_ff <= ovalid_in;
      end
      data_ff  <= data_in;
      fin_ff   <= fin_in;
      slot_ff  <= slot_in;
      ocode_ff <= ocode_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         hash_mem[slot_ff] <= '{code: lcmp_pkg::code_type'(free_ff),
                                prefix: prefix_ff, data: data_ff};
         link_mem[lcmp_pkg::code_type'(free_ff)] <= slot_ff;
      end
      hq_ff <= hash_mem[slot_ff];
      lq_ff <= link_mem[hq_ff.code];
   end

   assign out_valid = ovalid_ff;
   assign out_code  = ocode_ff;
   assign out_last  = olast_ff;

endmodule

/* verif/lzw_byte_compressor_checker.sv */
// Checker for the LZW byte compressor: watches the request and response channels,
// predicts the emitted codes and compares them in order.
// Depends on lcmp_pkg, lcmp_req_if and lcmp_rsp_if.
module lzw_byte_compressor_checker (
   input  logic   clock,
   input  logic   reset,
   lcmp_req_if    req_mon,
   lcmp_rsp_if    rsp_mon,
   output int     errors,
   output int     pending,
   output int     codes_checked,
   output int     frozen_misses
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      lcmp_pkg::out_code_type code;
      logic                   last;
   } emitted_code_type;

   // dictionary of the current stream, keyed by {prefix code, byte}
   lcmp_pkg::code_type   word_code [bit [lcmp_pkg::CODE_BITS+lcmp_pkg::DATA_BITS-1:0]];
   lcmp_pkg::code_type   cur_prefix;
   bit                   have_prefix;
   lcmp_pkg::free_type   free_code;
   emitted_code_type     expected_codes[$];

   task automatic report_mismatch(input string msg);
      if (errors < 40) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic restart_stream();
      word_code.delete();
      free_code   = lcmp_pkg::FIRST_FREE;
      cur_prefix  = '0;
      have_prefix = 1'b0;
   endtask

   task automatic compress_byte(input lcmp_pkg::data_type b, input logic fin);
      bit [lcmp_pkg::CODE_BITS+lcmp_pkg::DATA_BITS-1:0] key;
      key = {cur_prefix, b};
      if (!have_prefix) begin
         cur_prefix  = lcmp_pkg::code_type'(b);
         have_prefix = 1'b1;
      end else if (word_code.exists(key)) begin
         cur_prefix = word_code[key];
      end else begin
         expected_codes.push_back('{code: cur_prefix, last: 1'b0});
         if (free_code < lcmp_pkg::FREE_LIMIT) begin
            word_code[key] = lcmp_pkg::code_type'(free_code);
            free_code++;
         end else begin
            frozen_misses++;
         end
         cur_prefix = lcmp_pkg::code_type'(b);
      end
      if (fin) begin
         expected_codes.push_back('{code: cur_prefix, last: 1'b1});
         restart_stream();
      end
   endtask

   initial begin
      errors        = 0;
      pending       = 0;
      codes_checked = 0;
      frozen_misses = 0;
      restart_stream();
   end

   always @(posedge clock) begin
      emitted_code_type want;
      if (reset) begin
         restart_stream();
         expected_codes.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            compress_byte(req_mon.in_byte, req_mon.in_final);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("code %0d (last %b) with nothing expected",
                                         rsp_mon.out_code, rsp_mon.out_last));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_mon.out_code !== want.code)
                  report_mismatch($sformatf("out_code %0d, expected %0d",
                                            rsp_mon.out_code, want.code));
               if (rsp_mon.out_last !== want.last)
                  report_mismatch($sformatf("out_last %b, expected %b for code %0d",
                                            rsp_mon.out_last, want.last, want.code));
               codes_checked++;
            end
         end
      end
      pending = expected_codes.size();
   end

endmodule

/* verif/lzw_byte_compressor_test.sv */
// Top of the LZW byte compressor testbench: clock, reset, byte stimulus and
// response back-pressure. Depends on lcmp_pkg, the channel interfaces,
// lzw_byte_compressor and lzw_byte_compressor_checker.
module lzw_byte_compressor_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RANDOM_BYTES = 900;
   localparam int  LONG_FILL    = 600;
   // probe counts grow with hash table load, so leave a wide margin
   localparam longint CYCLE_LIMIT = 6_000_000;

   logic   clock;
   logic   reset;
   bit     calm;
   bit     code_taken;
   int     stall_left;
   longint cycles;
   int     bytes_sent;
   int     streams_sent;
   int     longest_stream;
   int     errors;
   int     pending;
   int     codes_checked;
   int     frozen_misses;

   lcmp_req_if req_chan ();
   lcmp_rsp_if rsp_chan ();

   lzw_byte_compressor dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   lzw_byte_compressor_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .errors        (errors),
      .pending       (pending),
      .codes_checked (codes_checked),
      .frozen_misses (frozen_misses)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d codes outstanding", cycles, pending);
         $display("lzw_byte_compressor_test: errors");
         $finish;
      end
   end

   // response back-pressure: a fresh random stall after every code taken, none while calm
   always @(posedge clock) code_taken <= rsp_chan.valid && rsp_chan.ready;

   always @(negedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (code_taken) stall_left = calm ? 0 : $urandom_range(0, 3);
         else if (stall_left != 0) stall_left--;
         rsp_chan.ready <= (stall_left == 0);
      end
   end

   task automatic send_stream(input lcmp_pkg::data_type seq[$]);
      int unsigned gap;
      for (int i = 0; i < seq.size(); i++) begin
         gap = calm ? 0 : $urandom_range(0, 3);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_chan.valid    <= 1'b1;
         req_chan.in_byte  <= seq[i];
         req_chan.in_final <= (i == seq.size() - 1);
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         @(negedge clock);
         bytes_sent++;
      end
      streams_sent++;
      if (seq.size() > longest_stream) longest_stream = seq.size();
   endtask

   // symbols >= 256 gives uniform bytes, otherwise base xor an offset below symbols
   task automatic add_bytes(inout lcmp_pkg::data_type seq[$], input int unsigned count,
                            input lcmp_pkg::data_type base, input int unsigned symbols);
      for (int unsigned i = 0; i < count; i++) begin
         if (symbols >= 256) seq.push_back(lcmp_pkg::data_type'($urandom_range(0, 255)));
         else seq.push_back(base ^ lcmp_pkg::data_type'($urandom_range(0, symbols - 1)));
      end
   endtask

   initial begin
      lcmp_pkg::data_type seq[$];
      lcmp_pkg::data_type base;
      int unsigned        kind;

      clock              = 1'b0;
      reset              = 1'b1;
      calm               = 1'b0;
      code_taken         = 1'b0;
      stall_left         = 0;
      cycles             = 0;
      bytes_sent         = 0;
      streams_sent       = 0;
      longest_stream     = 0;
      req_chan.valid     = 1'b0;
      req_chan.in_byte   = '0;
      req_chan.in_final  = 1'b0;
      rsp_chan.ready     = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one-byte streams at both byte extremes
      seq = {8'h00};
      send_stream(seq);
      seq = {8'hFF};
      send_stream(seq);
      // growing run of one byte, then a miss on the final byte
      seq = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_stream(seq);
      // alternating pair, ending on a dictionary hit
      seq = {8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41};
      send_stream(seq);
      seq = {8'h00, 8'hFF};
      send_stream(seq);

      // one long stream that builds a large dictionary, then reuses its entries
      calm = 1'b1;
      base = lcmp_pkg::data_type'($urandom_range(0, 255));
      seq.delete();
      add_bytes(seq, 200, base, 4);
      add_bytes(seq, LONG_FILL, base, 256);
      add_bytes(seq, 200, base, 4);
      send_stream(seq);

      while (bytes_sent < LONG_FILL + 400 + RANDOM_BYTES) begin
         calm = ($urandom_range(0, 4) == 0);
         base = lcmp_pkg::data_type'($urandom_range(0, 255));
         kind = $urandom_range(0, 9);
         seq.delete();
         if (kind <= 4) add_bytes(seq, $urandom_range(1, 60), base, $urandom_range(1, 4));
         else if (kind <= 7) add_bytes(seq, $urandom_range(1, 40), base, 16);
         else if (kind == 8) add_bytes(seq, $urandom_range(1, 30), base, 256);
         else add_bytes(seq, 1, base, 256);
         send_stream(seq);
      end
      req_chan.valid <= 1'b0;
      calm = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("sent %0d bytes in %0d streams (longest %0d), checked %0d codes",
               bytes_sent, streams_sent, longest_stream, codes_checked);
      $display("%0d misses seen with the dictionary full", frozen_misses);
      if (errors == 0)
         $display("lzw_byte_compressor_test: clean");
      else
         $display("lzw_byte_compressor_test: errors");
      $finish;
   end

endmodule

/* files.f */
rtl/lcmp_pkg.sv
rtl/lcmp_req_if.sv
rtl/lcmp_rsp_if.sv
rtl/lcmp_ctrl.sv
rtl/lcmp_dpath.sv
rtl/lzw_byte_compressor.sv
verif/lzw_byte_compressor_checker.sv
verif/lzw_byte_compressor_test.sv
